FILE: hw/rtl/mwcs_pkg.sv
package mwcs_pkg;

  // Field widths of the request and response words
  localparam int MaskW   = 10;
  localparam int WeightW = 16;
  localparam int EntryW  = 20;

  // Default sizing
  localparam int DefMaxVertices = 10;
  localparam int DefWeightBits  = 16;

  // Request operation codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage

FILE: hw/rtl/mwcs_if.sv
interface mwcs_req_if;
  import mwcs_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic               first;
  logic [WeightW-1:0] vertex_weight;
  logic [MaskW-1:0]   neighbor_mask;
  logic [MaskW-1:0]   subset_mask;

  modport source (output valid, func, first, vertex_weight, neighbor_mask, subset_mask,
                  input ready);
  modport sink   (input valid, func, first, vertex_weight, neighbor_mask, subset_mask,
                  output ready);
endinterface

interface mwcs_rsp_if;
  import mwcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [EntryW-1:0] clique_weight;
  logic              error;

  modport source (output valid, clique_weight, error, input ready);
  modport sink   (input valid, clique_weight, error, output ready);
endinterface

FILE: hw/rtl/max_weight_clique_subset_table.sv
// Adding vertex i fills entries 2^i up to 2^(i+1)-1, then passes S_FWAIT to S_PUT; a read
//   or an add past capacity passes S_RWAIT, a read naming absent vertices goes straight
//   to S_PUT. One word is in work at a time. Throughput is set by the table's single
//   write port: one entry of the fill per cycle.
// Reset clears the vertex count and all control; table contents are not cleared, and
//   entry zero always reads as zero.
module max_weight_clique_subset_table #(
  parameter int MAX_VERTICES = mwcs_pkg::DefMaxVertices,
  parameter int WEIGHT_BITS  = mwcs_pkg::DefWeightBits
) (
  input logic       clk,
  input logic       rst,
  mwcs_req_if.sink   req,
  mwcs_rsp_if.source rsp
);
  import mwcs_pkg::*;

  localparam int AW     = MAX_VERTICES;
  localparam int DEPTH  = 1 << AW;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int WB_USE = (WEIGHT_BITS < WeightW) ? WEIGHT_BITS : WeightW;
  localparam logic [WeightW-1:0] WMask = WeightW'((33'd1 << WB_USE) - 33'd1);
  localparam logic [EntryW-1:0]  EntryMax = {EntryW{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILL  = 5'b00010,
    S_FWAIT = 5'b00100,
    S_RWAIT = 5'b01000,
    S_PUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]      vertex_count;
  logic [AW-1:0]      start;
  logic [AW-1:0]      adj;
  logic [AW-1:0]      k;
  logic [WeightW-1:0] weight;
  logic [EntryW-1:0]  res;
  logic               res_err;

  // Fill pipeline: read stage to write stage
  logic               p_valid;
  logic [AW-1:0]      p_waddr;

  // Table memory
  logic [EntryW-1:0]  mem [0:DEPTH-1];
  logic [AW-1:0]      ra, rb;
  logic [EntryW-1:0]  rd_a, rd_b;
  logic               za, zb;
  logic [EntryW-1:0]  val_a, val_b;

  // Request decode
  logic               accept;
  logic [CW-1:0]      cnt_eff;
  logic               overflow;
  logic [AW-1:0]      start_in;
  logic [AW+MaskW-1:0] nmask_ext, smask_ext;
  logic [AW-1:0]      nmask_aw, smask_aw;
  logic [MaskW-1:0]   bad_bits;
  logic               k_last;

  // Entry update
  logic [EntryW:0]    with_sum;
  logic [EntryW-1:0]  with_sat;
  logic [EntryW-1:0]  best;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign cnt_eff   = (req.func == FUNC_ADD && req.first) ? '0 : vertex_count;
  assign overflow  = 32'(cnt_eff) >= MAX_VERTICES;
  assign start_in  = AW'(1) << cnt_eff;
  assign nmask_ext = {{AW{1'b0}}, req.neighbor_mask};
  assign smask_ext = {{AW{1'b0}}, req.subset_mask};
  assign nmask_aw  = nmask_ext[AW-1:0];
  assign smask_aw  = smask_ext[AW-1:0];
  assign k_last    = (k == start - AW'(1));

  // Flag subset bits that name vertices not yet loaded
  always_comb begin
    for (int b = 0; b < MaskW; b++) begin
      bad_bits[b] = req.subset_mask[b] && (b >= 32'(vertex_count));
    end
  end

  // Select read addresses: request path when idle, fill offsets otherwise
  always_comb begin
    if (state == S_IDLE) begin
      ra = (req.func == FUNC_READ) ? smask_aw : {AW{1'b1}};
    end else begin
      ra = k;
    end
    rb = adj & k;
  end

  // Table: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (p_valid) begin
      mem[p_waddr] <= best;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
    za   <= (ra == '0);
    zb   <= (rb == '0);
  end

  // Entry zero is the empty set and never written
  assign val_a = za ? '0 : rd_a;
  assign val_b = zb ? '0 : rd_b;

  // Take the larger of the entry without the vertex and the one with it
  always_comb begin
    with_sum = {1'b0, val_b} + (EntryW + 1)'(weight);
    with_sat = with_sum[EntryW] ? EntryMax : with_sum[EntryW-1:0];
    best     = (with_sat > val_a) ? with_sat : val_a;
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_READ) begin
            state_next = (bad_bits != '0) ? S_PUT : S_RWAIT;
          end else begin
            state_next = overflow ? S_RWAIT : S_FILL;
          end
        end
      end
      S_FILL:  state_next = k_last ? S_FWAIT : S_FILL;
      S_FWAIT: state_next = S_PUT;
      S_RWAIT: state_next = S_PUT;
      S_PUT:   state_next = (!rsp.valid || rsp.ready) ? S_IDLE : S_PUT;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      p_valid      <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == S_FILL);
      if (accept && req.func == FUNC_ADD && !overflow) begin
        vertex_count <= cnt_eff + CW'(1);
      end
      if (state == S_PUT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Latch the add word and the fill range
    if (accept) begin
      start   <= start_in;
      adj     <= nmask_aw & (start_in - AW'(1));
      weight  <= req.vertex_weight & WMask;
      k       <= '0;
      res     <= '0;
      res_err <= (req.func == FUNC_READ) ? (bad_bits != '0) : overflow;
    end else if (state == S_FILL) begin
      k <= k + AW'(1);
    end
    p_waddr <= start | k;
    // Hold the result until the response register is free
    if (state == S_FWAIT) begin
      res <= best;
    end else if (state == S_RWAIT) begin
      res <= val_a;
    end
    if (state == S_PUT && (!rsp.valid || rsp.ready)) begin
      rsp.clique_weight <= res;
      rsp.error         <= res_err;
    end
  end

endmodule

FILE: tb/clique_table_checker.sv
`timescale 1ns / 100ps

module clique_table_checker
  import mwcs_pkg::*;
#(
  parameter int MaxVertices = DefMaxVertices,
  parameter int WeightBits  = DefWeightBits
) (
  input  logic clk,
  input  logic rst,
  mwcs_req_if  req_mon,
  mwcs_rsp_if  rsp_mon,
  output int   fail_count,
  output int   pending
);

  localparam int TableDepth = 1 << MaxVertices;
  localparam longint unsigned EntryMax = (64'd1 << EntryW) - 1;

  typedef struct packed {
    logic [EntryW-1:0] weight;
    logic              err;
  } clique_word_t;

  // Shadow copy of the subset table and the loaded vertex count
  logic [EntryW-1:0] best_entry [TableDepth];
  int                vert_count;
  clique_word_t      expected_clique_words [$];

  // Update the shadow table for one request word and return the response it should cause
  function automatic clique_word_t predict_clique_word(
    input logic              func,
    input logic              first,
    input logic [WeightW-1:0] weight,
    input logic [MaskW-1:0]   nbr,
    input logic [MaskW-1:0]   subset
  );
    clique_word_t    word;
    longint unsigned w_used, w_excl, w_incl, w_best;
    int              base, adj, live;
    word   = '0;
    w_used = longint'(weight) & ((64'd1 << WeightBits) - 1);
    if (func == FUNC_ADD) begin
      if (first) vert_count = 0;
      if (vert_count < MaxVertices) begin
        base = 1 << vert_count;
        // drop neighbor bits at or above the new vertex
        adj  = int'(nbr) & (base - 1);
        for (int j = base; j < 2 * base; j++) begin
          w_excl = longint'(best_entry[j - base]);
          w_incl = longint'(best_entry[adj & j]) + w_used;
          w_best = (w_incl > w_excl) ? w_incl : w_excl;
          if (w_best > EntryMax) w_best = EntryMax;
          best_entry[j] = w_best[EntryW-1:0];
        end
        vert_count++;
      end else begin
        word.err = 1'b1;
      end
      word.weight = best_entry[((1 << vert_count) - 1) & (TableDepth - 1)];
    end else begin
      live = (1 << vert_count) - 1;
      if ((int'(subset) & ~live) != 0) begin
        word.err = 1'b1;
      end else begin
        word.weight = best_entry[int'(subset) & (TableDepth - 1)];
      end
    end
    return word;
  endfunction

  // Compare each response word with the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    clique_word_t got, want;
    int           bumps;
    bumps = 0;
    if (rst) begin
      vert_count    = 0;
      best_entry[0] = '0;
      expected_clique_words.delete();
      fail_count <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.weight = rsp_mon.clique_weight;
        got.err    = rsp_mon.error;
        if (expected_clique_words.size() == 0) begin
          $display("%0t: unexpected response word: clique_weight %0d error %0b",
                   $time, got.weight, got.err);
          bumps++;
        end else begin
          want = expected_clique_words.pop_front();
          if (got.weight !== want.weight) begin
            $display("%0t: clique_weight mismatch: expected %0d actual %0d",
                     $time, want.weight, got.weight);
            bumps++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error mismatch: expected %0b actual %0b",
                     $time, want.err, got.err);
            bumps++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_clique_words.push_back(predict_clique_word(req_mon.func, req_mon.first,
          req_mon.vertex_weight, req_mon.neighbor_mask, req_mon.subset_mask));
      end
      fail_count <= fail_count + bumps;
    end
    pending <= expected_clique_words.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mwcs_pkg::*;

  localparam int MaxVert    = DefMaxVertices;
  localparam int ItemTarget = 580;
  localparam int IdleLimit  = 20000;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   words_sent = 0;
  int   loaded = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  mwcs_req_if req_bus ();
  mwcs_rsp_if rsp_bus ();

  max_weight_clique_subset_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  clique_table_checker table_check (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_bus),
    .rsp_mon    (rsp_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Push one request word, idling between bursts, and track how many vertices are loaded
  task automatic send_word(
    input logic               func,
    input logic               first,
    input logic [WeightW-1:0] weight,
    input logic [MaskW-1:0]   nbr,
    input logic [MaskW-1:0]   subset
  );
    int gap;
    if (burst_left == 0) begin
      req_bus.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    req_bus.valid         <= 1'b1;
    req_bus.func          <= func;
    req_bus.first         <= first;
    req_bus.vertex_weight <= weight;
    req_bus.neighbor_mask <= nbr;
    req_bus.subset_mask   <= subset;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
    if (func == FUNC_ADD) begin
      if (first) loaded = 0;
      if (loaded < MaxVert) loaded++;
    end
  endtask

  // Hold off the sender until every response has come back
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return WeightW'($urandom);
    endcase
  endfunction

  // Mostly subsets of the loaded vertices, now and then any mask at all
  function automatic logic [MaskW-1:0] read_mask();
    int live;
    live = (1 << loaded) - 1;
    case ($urandom_range(0, 7))
      0:       return MaskW'($urandom);
      1:       return MaskW'(live);
      default: return MaskW'($urandom & live);
    endcase
  endfunction

  // Response side: switch between free-running, choppy and slow stretches
  initial begin
    rx_mode_t mode;
    int       left;
    rsp_bus.ready = 1'b0;
    mode = RX_FREE;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        left = $urandom_range(32, 256);
      end
      left--;
      case (mode)
        RX_FREE:   rsp_bus.ready <= 1'b1;
        RX_CHOPPY: rsp_bus.ready <= 1'($urandom_range(0, 1));
        default:   rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Abort if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_vert;
    int n_reads;
    req_bus.valid         = 1'b0;
    req_bus.func          = FUNC_ADD;
    req_bus.first         = 1'b0;
    req_bus.vertex_weight = '0;
    req_bus.neighbor_mask = '0;
    req_bus.subset_mask   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reads on an empty graph, a full build, overflow, restart
    send_word(FUNC_READ, 1'b0, '0, '0, '0);
    send_word(FUNC_READ, 1'b1, '1, '1, 10'h200);
    for (int v = 0; v < MaxVert; v++) begin
      send_word(FUNC_ADD, v == 0,
                (v == 0) ? 16'h0000 : (v == 1) ? 16'hFFFF : rand_weight(),
                (v == MaxVert - 1) ? 10'h000 :
                (v % 3 == 0) ? 10'h3FF : (v % 3 == 1) ? 10'h155 : 10'h2AA,
                MaskW'($urandom));
    end
    send_word(FUNC_ADD, 1'b0, '1, '1, '1);
    send_word(FUNC_READ, 1'b0, '0, '0, 10'h3FF);
    send_word(FUNC_READ, 1'b0, '1, '1, 10'h155);
    send_word(FUNC_READ, 1'b0, '0, '0, 10'h000);
    send_word(FUNC_ADD, 1'b1, 16'hFFFF, 10'h3FF, '0);
    send_word(FUNC_READ, 1'b0, '0, '0, 10'h002);
    send_word(FUNC_READ, 1'b0, '0, '0, 10'h001);
    wait_for_results();

    // Random graphs: mostly small, a few at full capacity, with reads and noise mixed in
    while (words_sent < ItemTarget) begin
      n_vert = ($urandom_range(0, 19) == 0) ? MaxVert : $urandom_range(1, 6);
      for (int v = 0; v < n_vert; v++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), WeightW'($urandom),
                    MaskW'($urandom), MaskW'($urandom));
        end
        send_word(FUNC_ADD, v == 0, rand_weight(), MaskW'($urandom), MaskW'($urandom));
        n_reads = $urandom_range(0, 2);
        repeat (n_reads) begin
          send_word(FUNC_READ, 1'($urandom_range(0, 1)), WeightW'($urandom),
                    MaskW'($urandom), read_mask());
        end
      end
      if (n_vert == MaxVert) begin
        repeat ($urandom_range(1, 2)) begin
          send_word(FUNC_ADD, 1'b0, rand_weight(), MaskW'($urandom), MaskW'($urandom));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end

    // Drain and let the pipeline settle
    req_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
